// File: hw/rtl/waypoint_steering_step_macros.svh
// Assertion macros for the waypoint steering checker.
// No dependencies; included by the checker file.
`ifndef WAYPOINT_STEERING_STEP_MACROS_SVH
`define WAYPOINT_STEERING_STEP_MACROS_SVH

// implication checked on every clock edge outside reset
`define WSS_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("wss check failed");

// next-cycle implication checked outside reset
`define WSS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("wss check failed");

// next-cycle implication that also holds across reset
`define WSS_ASSERT_NEXT_ALWAYS(lbl, clk, ante, cons) \
    lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("wss check failed");

`endif

// File: hw/rtl/wss_pkg.sv
// Shared types, constants and tables of the waypoint steering block.
// No dependencies.
`default_nettype none
package wss_pkg;

    localparam int CORDIC_STEPS = 16;
    localparam int CNT_STEPS    = (CORDIC_STEPS > 16) ? CORDIC_STEPS : 16;
    localparam int CNT_W        = $clog2(CNT_STEPS);
    localparam int DIV_STEPS    = 16;

    localparam int CW = 36;  // cordic x/y width
    localparam int ZW = 20;  // cordic angle width

    localparam logic signed [17:0] PI13     = 18'sd25736;
    localparam logic signed [19:0] PI16     = 20'sd205888;
    localparam logic signed [19:0] HALFPI16 = 20'sd102944;
    localparam logic signed [CW-1:0] INVK30 = CW'(652032874);
    localparam logic signed [24:0] INVK24   = 25'sd10188014;

    localparam logic [4:0] ADDR_W = 5'd5;

    typedef enum logic [2:0] {
        REG_SPEED_STEP   = 3'd0,
        REG_TURN_GAIN    = 3'd1,
        REG_NEAR_DIST    = 3'd2,
        REG_FAR_DIST     = 3'd3,
        REG_SLEW_LIMIT   = 3'd4,
        REG_ARRIVAL_RAD  = 3'd5
    } t_reg_idx;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_VEC,
        ST_MLO,
        ST_MHI,
        ST_DIST,
        ST_HEAD,
        ST_GMUL,
        ST_DIVCHK,
        ST_DIV,
        ST_TGT,
        ST_ROT,
        ST_MSIN,
        ST_MCOS,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic load;
        logic step;
        logic rotate;
    } t_cordic_ctl;

    function automatic logic signed [ZW-1:0] atan_lut(input logic [CNT_W-1:0] idx);
        logic signed [ZW-1:0] v;
        case (idx)
            CNT_W'(0):  v = ZW'(51472);
            CNT_W'(1):  v = ZW'(30386);
            CNT_W'(2):  v = ZW'(16055);
            CNT_W'(3):  v = ZW'(8150);
            CNT_W'(4):  v = ZW'(4091);
            CNT_W'(5):  v = ZW'(2047);
            CNT_W'(6):  v = ZW'(1024);
            CNT_W'(7):  v = ZW'(512);
            CNT_W'(8):  v = ZW'(256);
            CNT_W'(9):  v = ZW'(128);
            CNT_W'(10): v = ZW'(64);
            CNT_W'(11): v = ZW'(32);
            CNT_W'(12): v = ZW'(16);
            CNT_W'(13): v = ZW'(8);
            CNT_W'(14): v = ZW'(4);
            CNT_W'(15): v = ZW'(2);
            default: begin
                if (idx == CNT_W'(16)) v = ZW'(1);
                else                   v = '0;
            end
        endcase
        return v;
    endfunction

endpackage
`default_nettype wire

// File: hw/rtl/wss_cordic.sv
// Shared CORDIC iteration unit, vectoring or rotation mode, one step a cycle while i_ctl.step is set.
// Depends on wss_pkg.
`default_nettype none
module wss_cordic
    import wss_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire t_cordic_ctl          i_ctl,
    input  wire logic [CNT_W-1:0]     i_iter,
    input  wire logic signed [CW-1:0] i_x0,
    input  wire logic signed [CW-1:0] i_y0,
    input  wire logic signed [ZW-1:0] i_z0,
    output logic signed [CW-1:0]      o_x,
    output logic signed [CW-1:0]      o_y,
    output logic signed [ZW-1:0]      o_z
);

    logic signed [CW-1:0] r_x, r_y;
    logic signed [ZW-1:0] r_z;
    logic signed [CW-1:0] xs, ys;
    logic                 pos_dir;

    always_comb begin
        xs      = r_x >>> i_iter;
        ys      = r_y >>> i_iter;
        pos_dir = i_ctl.rotate ? !r_z[ZW-1] : r_y[CW-1];
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_x <= i_x0;
            r_y <= i_y0;
            r_z <= i_z0;
        end else if (i_ctl.step) begin
            if (pos_dir) begin
                r_x <= r_x - ys;
                r_y <= r_y + xs;
                r_z <= r_z - atan_lut(i_iter);
            end else begin
                r_x <= r_x + ys;
                r_y <= r_y - xs;
                r_z <= r_z + atan_lut(i_iter);
            end
        end
    end

    assign o_x = r_x;
    assign o_y = r_y;
    assign o_z = r_z;

endmodule
`default_nettype wire

// File: hw/rtl/waypoint_steering_step.sv
// Waypoint steering controller: one pose update per word, shared CORDIC unit.
// A new input word is accepted only in the idle state, after the previous result
// has been taken; any output stall holds the block in its done state. The shared CORDIC
// unit and the 16-step divider are used in turn for each word.
// Reset: pose, turn rate and control cleared, registers to defaults.
// Depends on wss_pkg and wss_cordic.
`default_nettype none
module waypoint_steering_step
    import wss_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output logic                    o_in_stall,
    input  wire logic signed [31:0] i_dest_x,
    input  wire logic signed [31:0] i_dest_y,
    input  wire logic               i_new_target,
    output logic                    o_out_valid,
    input  wire logic               i_out_stall,
    output logic signed [31:0]      o_pos_x,
    output logic signed [31:0]      o_pos_y,
    output logic [31:0]             o_distance,
    output logic                    o_arrived,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [ADDR_W-1:0]  paddr,
    input  wire logic [31:0]        pwdata,
    output logic [31:0]             prdata,
    output logic                    pready
);

    t_state r_state, n_state;

    logic [19:0] r_speed;
    logic [15:0] r_gain;
    logic [31:0] r_near, r_far, r_arr_rad;
    logic [14:0] r_slew;

    logic signed [31:0] r_east, r_north;
    logic signed [15:0] r_orient, r_rate;

    logic signed [32:0] r_dx, r_dy;
    logic               r_new;
    logic [CNT_W-1:0]   r_cnt;
    logic signed [60:0] r_acc;
    logic signed [17:0] r_err;
    logic [31:0]        r_dc;
    logic [34:0]        r_rem;
    logic [46:0]        r_den;
    logic [16:0]        r_q;
    logic               r_qneg;
    logic signed [15:0] r_tgt;
    logic               r_neg;
    logic               r_out_valid;
    logic               r_arrived;
    logic [31:0]        r_dist;
    logic signed [31:0] r_out_x, r_out_y;

    t_cordic_ctl          cctl;
    logic signed [CW-1:0] c_x0, c_y0, c_x, c_y;
    logic signed [ZW-1:0] c_z0, c_z;

    logic in_acc, cfg_wr, cnt_last;
    logic signed [32:0] dx_in, dy_in;

    logic signed [CW-1:0] mul_a;
    logic signed [24:0]   mul_b;
    logic signed [60:0]   prod;

    always_comb begin
        in_acc   = i_in_valid && !o_in_stall;
        cfg_wr   = psel && penable && pwrite && pready;
        dx_in    = 33'(i_dest_x) - 33'(r_east);
        dy_in    = 33'(i_dest_y) - 33'(r_north);
        cnt_last = (r_state == ST_DIV) ? (r_cnt == CNT_W'(DIV_STEPS - 1))
                                       : (r_cnt == CNT_W'(CORDIC_STEPS - 1));
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:   if (in_acc) n_state = ST_VEC;
            ST_VEC:    if (cnt_last) n_state = ST_MLO;
            ST_MLO:    n_state = ST_MHI;
            ST_MHI:    n_state = ST_DIST;
            ST_DIST:   n_state = ST_HEAD;
            ST_HEAD:   n_state = (r_new && r_arrived) ? ST_DONE : ST_GMUL;
            ST_GMUL:   n_state = ST_DIVCHK;
            ST_DIVCHK: begin
                if (r_dc == '0 || {13'b0, r_rem} >= {r_dc, 16'b0}) n_state = ST_TGT;
                else n_state = ST_DIV;
            end
            ST_DIV:    if (cnt_last) n_state = ST_TGT;
            ST_TGT:    n_state = ST_ROT;
            ST_ROT:    if (cnt_last) n_state = ST_MSIN;
            ST_MSIN:   n_state = ST_MCOS;
            ST_MCOS:   n_state = ST_DONE;
            ST_DONE:   if (!r_out_valid) n_state = ST_IDLE;
            default:   n_state = ST_IDLE;
        endcase
    end

    // outputs of the sequencer
    logic signed [19:0] fold_a;
    logic               fold_neg;
    always_comb begin
        o_in_stall  = (r_state != ST_IDLE);
        cctl        = '0;
        c_x0        = '0;
        c_y0        = '0;
        c_z0        = '0;
        mul_a       = '0;
        mul_b       = '0;
        fold_a      = {{1{r_orient[15]}}, r_orient, 3'b0};
        fold_neg    = 1'b0;
        if (fold_a > HALFPI16) begin
            fold_a   = fold_a - PI16;
            fold_neg = 1'b1;
        end else if (fold_a < -HALFPI16) begin
            fold_a   = fold_a + PI16;
            fold_neg = 1'b1;
        end
        unique case (r_state)
            ST_IDLE: begin
                cctl.load = in_acc;
                c_x0 = CW'(dy_in[32] ? -dy_in : dy_in);
                c_y0 = CW'(dx_in[32] ? -dx_in : dx_in);
            end
            ST_VEC: cctl.step = 1'b1;
            ST_MLO: begin
                mul_a = CW'({1'b0, c_x[16:0]});
                mul_b = INVK24;
            end
            ST_MHI: begin
                mul_a = CW'({1'b0, c_x[33:17]});
                mul_b = INVK24;
            end
            ST_GMUL: begin
                mul_a = CW'(r_err);
                mul_b = 25'({1'b0, r_gain});
            end
            ST_TGT: begin
                cctl.load = 1'b1;
                c_x0 = INVK30;
                c_z0 = fold_a;
            end
            ST_ROT: begin
                cctl.step   = 1'b1;
                cctl.rotate = 1'b1;
            end
            ST_MSIN: begin
                mul_a = r_neg ? -c_y : c_y;
                mul_b = 25'({1'b0, r_speed});
            end
            ST_MCOS: begin
                mul_a = r_neg ? -c_x : c_x;
                mul_b = 25'({1'b0, r_speed});
            end
            ST_DIST, ST_HEAD, ST_DIVCHK, ST_DIV, ST_DONE: ;
            default: ;
        endcase
        prod = 61'(mul_a) * 61'(mul_b);
    end

    wss_cordic u_cordic (
        .i_clk  (i_clk),
        .i_ctl  (cctl),
        .i_iter (r_cnt),
        .i_x0   (c_x0),
        .i_y0   (c_y0),
        .i_z0   (c_z0),
        .o_x    (c_x),
        .o_y    (c_y),
        .o_z    (c_z)
    );

    // datapath helpers
    logic signed [60:0] rnd_d;
    logic [31:0]        d_val;
    logic signed [16:0] alpha;
    logic signed [17:0] heading, err_w;
    logic [31:0]        dc_w;
    logic signed [60:0] p_abs;
    logic signed [17:0] tgt_q, diff, slew_s, t_sat, orient_t;
    logic signed [60:0] step_r;

    always_comb begin
        rnd_d = r_acc + 61'sd8388608;
        d_val = (rnd_d[60:56] != '0) ? 32'hFFFF_FFFF : 32'(rnd_d[55:24]);

        alpha = 17'((c_z + 20'sd4) >>> 3);
        if (r_dx == 33'sd0 && r_dy <= 33'sd0) heading = -PI13;
        else if (r_dy >= 33'sd0) heading = (r_dx > 33'sd0) ? -18'(alpha) : 18'(alpha);
        else heading = (r_dx > 33'sd0) ? -(PI13 - 18'(alpha)) : (PI13 - 18'(alpha));
        err_w = heading - 18'(r_orient);
        if (err_w > PI13)  err_w = err_w - 18'(2 * PI13);
        if (err_w < -PI13) err_w = err_w + 18'(2 * PI13);

        if (r_dist < r_near)     dc_w = r_near;
        else if (r_dist > r_far) dc_w = r_far;
        else                     dc_w = r_dist;

        p_abs = prod[60] ? -prod : prod;

        if (r_qneg) tgt_q = (r_q > 17'd32768) ? -18'sd32768 : -18'($signed({1'b0, r_q}));
        else        tgt_q = (r_q > 17'd32767) ? 18'sd32767 : 18'($signed({1'b0, r_q}));
        diff   = tgt_q - 18'(r_rate);
        slew_s = $signed({3'b0, r_slew});
        t_sat  = tgt_q;
        if (diff > slew_s)  t_sat = 18'(r_rate) + slew_s;
        if (diff < -slew_s) t_sat = 18'(r_rate) - slew_s;
        if (t_sat > 18'sd32767)  t_sat = 18'sd32767;
        if (t_sat < -18'sd32768) t_sat = -18'sd32768;

        orient_t = 18'(r_orient) + 18'(r_tgt);
        if (orient_t >= PI13) orient_t = orient_t - 18'(2 * PI13);
        if (orient_t < -PI13) orient_t = orient_t + 18'(2 * PI13);

        step_r = (prod + 61'sd536870912) >>> 30;
    end

    // control and state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
            r_cnt       <= '0;
            r_east      <= '0;
            r_north     <= '0;
            r_orient    <= '0;
            r_rate      <= '0;
            r_speed     <= 20'd13107;
            r_gain      <= 16'd2867;
            r_near      <= 32'd262144;
            r_far       <= 32'd589824;
            r_slew      <= 15'd819;
            r_arr_rad   <= 32'd65536;
        end else begin
            r_state <= n_state;
            if (r_state == ST_DIST) r_out_valid <= 1'b1;
            else if (r_out_valid && !i_out_stall) r_out_valid <= 1'b0;

            if (n_state != r_state) r_cnt <= '0;
            else r_cnt <= r_cnt + CNT_W'(1);

            if (r_state == ST_MSIN) r_east <= r_east - 32'(step_r);
            if (r_state == ST_MCOS) begin
                r_north  <= r_north + 32'(step_r);
                r_rate   <= r_tgt;
                r_orient <= 16'(orient_t);
            end

            if (cfg_wr) begin
                unique case (paddr[4:2])
                    REG_SPEED_STEP:  r_speed   <= pwdata[19:0];
                    REG_TURN_GAIN:   r_gain    <= pwdata[15:0];
                    REG_NEAR_DIST:   r_near    <= pwdata;
                    REG_FAR_DIST:    r_far     <= pwdata;
                    REG_SLEW_LIMIT:  r_slew    <= pwdata[14:0];
                    REG_ARRIVAL_RAD: r_arr_rad <= pwdata;
                    default: ;
                endcase
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_IDLE: begin
                r_dx  <= dx_in;
                r_dy  <= dy_in;
                r_new <= i_new_target;
            end
            ST_MLO: r_acc <= prod;
            ST_MHI: r_acc <= r_acc + (prod <<< 17);
            ST_DIST: begin
                r_dist    <= d_val;
                r_arrived <= (d_val <= r_arr_rad);
                r_out_x   <= r_east;
                r_out_y   <= r_north;
            end
            ST_HEAD: begin
                r_err <= err_w;
                r_dc  <= dc_w;
            end
            ST_GMUL: begin
                r_rem  <= 35'(p_abs <<< 4);
                r_qneg <= prod[60];
                r_q    <= '0;
            end
            ST_DIVCHK: begin
                r_den <= {r_dc, 15'b0};
                if (r_dc == '0) begin
                    r_qneg <= r_err[17];
                    if (r_err > 18'sd0)      r_q <= 17'd32767;
                    else if (r_err < 18'sd0) r_q <= 17'd32768;
                    else                     r_q <= '0;
                end else if ({13'b0, r_rem} >= {r_dc, 16'b0}) begin
                    r_q <= 17'h10000;
                end
            end
            ST_DIV: begin
                r_den <= r_den >> 1;
                if ({12'b0, r_rem} >= r_den) begin
                    r_rem <= r_rem - 35'(r_den);
                    r_q   <= {r_q[15:0], 1'b1};
                end else begin
                    r_q   <= {r_q[15:0], 1'b0};
                end
            end
            ST_TGT: begin
                r_tgt <= 16'(t_sat);
                r_neg <= fold_neg;
            end
            default: ;
        endcase
    end

    always_comb begin
        pready = 1'b1;
        prdata = '0;
        case (paddr[4:2])
            REG_SPEED_STEP:  prdata = {12'b0, r_speed};
            REG_TURN_GAIN:   prdata = {16'b0, r_gain};
            REG_NEAR_DIST:   prdata = r_near;
            REG_FAR_DIST:    prdata = r_far;
            REG_SLEW_LIMIT:  prdata = {17'b0, r_slew};
            REG_ARRIVAL_RAD: prdata = r_arr_rad;
            default:         prdata = '0;
        endcase
    end

    assign o_out_valid = r_out_valid;
    assign o_pos_x     = r_out_x;
    assign o_pos_y     = r_out_y;
    assign o_distance  = r_dist;
    assign o_arrived   = r_arrived;

endmodule
`default_nettype wire

// File: hw/rtl/wss_checker.sv
// Port-level checks of the waypoint steering block, bound to the top level.
// Depends on wss_pkg and waypoint_steering_step_macros.svh.
`default_nettype none
`include "waypoint_steering_step_macros.svh"
module wss_checker
    import wss_pkg::*;
(
    input wire logic               i_clk,
    input wire logic               i_rst_n,
    input wire logic               i_in_valid,
    input wire logic               o_in_stall,
    input wire logic               o_out_valid,
    input wire logic               i_out_stall,
    input wire logic signed [31:0] o_pos_x,
    input wire logic [31:0]        o_distance
);

    logic in_acc;
    assign in_acc = i_in_valid && !o_in_stall;

    `WSS_ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, in_acc, o_in_stall)
    `WSS_ASSERT_IMP(a_no_accept_while_result, i_clk, i_rst_n, o_out_valid, o_in_stall)
    `WSS_ASSERT_NEXT(a_result_held, i_clk, i_rst_n, o_out_valid && i_out_stall,
        o_out_valid && $stable(o_pos_x) && $stable(o_distance))
    `WSS_ASSERT_NEXT_ALWAYS(a_reset_clears, i_clk, !i_rst_n, !o_out_valid && !o_in_stall)

endmodule

bind waypoint_steering_step wss_checker u_wss_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_pos_x     (o_pos_x),
    .o_distance  (o_distance)
);
`default_nettype wire
